// ===== src/key_press_classifier_macros.svh =====
// ----------------------------------------------------------------------------
// Key press classifier assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef KEY_PRESS_CLASSIFIER_MACROS_SVH
`define KEY_PRESS_CLASSIFIER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define KPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define KPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/kpc_pkg.sv =====
// ----------------------------------------------------------------------------
// kpc_pkg
// Types and constants shared by the key press classifier modules.
// ----------------------------------------------------------------------------
package kpc_pkg;

  localparam int NUM_KEYS    = 3;
  localparam int COUNT_WIDTH = 32;
  localparam int LEVEL_BITS  = 3;
  localparam int HOLD_WIDTH  = 32;
  localparam int THR_WIDTH   = 16;
  localparam int CFG_WIDTH   = 16;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [THR_WIDTH-1:0]   thr_t;
  typedef logic [HOLD_WIDTH-1:0]  hold_t;

  localparam thr_t SHORT_RESET = thr_t'(100);
  localparam thr_t LONG_RESET  = thr_t'(1000);

  // Request codes
  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_PRESS = 3'd1,
    REQ_LONG  = 3'd2,
    REQ_ACT   = 3'd3,
    REQ_HOLD  = 3'd4
  } req_code_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_REPEAT = 2'd0,
    REG_SHORT  = 2'd1,
    REG_LONG   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0]            req_type;
    logic [LEVEL_BITS-1:0] key_levels;
    logic [1:0]            key_index;
  } req_t;

  typedef struct packed {
    logic  flag;
    hold_t hold_time;
  } rsp_t;

  // Per-key control from the top level
  typedef struct packed {
    logic tick;
    logic pressed;
    logic repeat_on;
    logic clr_press;
    logic clr_long;
  } lane_ctl_t;

  // Per-key status toward the merge stage
  typedef struct packed {
    logic   press_flag;
    logic   long_flag;
    logic   act_hit;
    count_t hold;
  } lane_sts_t;

endpackage

// ===== src/kpc_lane.sv =====
// ----------------------------------------------------------------------------
// kpc_lane
// One key: hold counter, debounce, short/long press and repeat flags.
// ----------------------------------------------------------------------------
module kpc_lane (
  input  logic                clk,
  input  logic                rst,
  input  kpc_pkg::lane_ctl_t  ctl,
  input  kpc_pkg::thr_t       short_thr,
  input  kpc_pkg::thr_t       long_thr,
  output kpc_pkg::lane_sts_t  sts
);

  localparam kpc_pkg::count_t COUNT_MAX = '1;

  kpc_pkg::count_t cnt, cnt_next, cnt_inc, short_ext, long_ext;
  logic            deb, deb_next;
  logic            press, press_next;
  logic            lng, lng_next;
  logic            act_hit;

  assign short_ext = kpc_pkg::count_t'(short_thr);
  assign long_ext  = kpc_pkg::count_t'(long_thr);
  // saturate at the top of the counter
  assign cnt_inc   = (cnt == COUNT_MAX) ? cnt : cnt + kpc_pkg::count_t'(1);

  always_comb begin
    cnt_next   = cnt;
    deb_next   = deb;
    press_next = press;
    lng_next   = lng;
    act_hit    = 1'b0;
    if (ctl.tick) begin
      if (ctl.pressed) begin
        cnt_next = cnt_inc;
        if (cnt_inc > short_ext) begin
          act_hit = 1'b1;
          if (cnt_inc > long_ext) begin
            if (deb) begin
              lng_next = 1'b1;
            end
          end else if (!ctl.repeat_on) begin
            deb_next = 1'b1;
          end else begin
            press_next = 1'b1;
            cnt_next   = '0;
          end
        end
      end else begin
        // decide short press, then drop the hold state
        if (!ctl.repeat_on && deb && !lng) begin
          press_next = 1'b1;
        end
        cnt_next = '0;
        deb_next = 1'b0;
        lng_next = 1'b0;
      end
    end else begin
      if (ctl.clr_press) begin
        press_next = 1'b0;
      end
      if (ctl.clr_long) begin
        lng_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      deb   <= 1'b0;
      press <= 1'b0;
      lng   <= 1'b0;
    end else begin
      cnt   <= cnt_next;
      deb   <= deb_next;
      press <= press_next;
      lng   <= lng_next;
    end
  end

  always_comb begin
    sts.press_flag = press;
    sts.long_flag  = lng;
    sts.act_hit    = act_hit;
    sts.hold       = cnt;
  end

endmodule

// ===== src/kpc_merge.sv =====
// ----------------------------------------------------------------------------
// kpc_merge
// Combines lane status into the activity flag and the registered result.
// ----------------------------------------------------------------------------
module kpc_merge (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  kpc_pkg::req_t      req,
  input  kpc_pkg::lane_sts_t lanes [kpc_pkg::NUM_KEYS],
  input  logic               rsp_stall,
  output logic               rsp_valid,
  output kpc_pkg::rsp_t      rsp_data
);

  logic               activity, activity_next;
  logic               any_hit, in_range;
  kpc_pkg::lane_sts_t sel;
  kpc_pkg::rsp_t      result;

  always_comb begin
    any_hit = 1'b0;
    sel     = '0;
    for (int k = 0; k < kpc_pkg::NUM_KEYS; k++) begin
      any_hit = any_hit | lanes[k].act_hit;
      if (int'(req.key_index) == k) begin
        sel = lanes[k];
      end
    end
  end

  assign in_range = int'(req.key_index) < kpc_pkg::NUM_KEYS;

  always_comb begin
    result = '0;
    case (req.req_type)
      kpc_pkg::REQ_PRESS: result.flag = in_range & sel.press_flag;
      kpc_pkg::REQ_LONG:  result.flag = in_range & sel.long_flag;
      kpc_pkg::REQ_ACT:   result.flag = activity;
      kpc_pkg::REQ_HOLD: begin
        if (in_range) begin
          result.hold_time = kpc_pkg::hold_t'(sel.hold);
        end
      end
      default: result = '0;
    endcase
  end

  always_comb begin
    activity_next = activity;
    if (accept) begin
      if (req.req_type == kpc_pkg::REQ_TICK && any_hit) begin
        activity_next = 1'b1;
      end else if (req.req_type == kpc_pkg::REQ_ACT) begin
        activity_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      activity  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      activity <= activity_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_data <= result;
    end
  end

endmodule

// ===== src/key_press_classifier.sv =====
// ----------------------------------------------------------------------------
// key_press_classifier
// Debounces three active-low keys and classifies short, long and repeated
// presses; queries read and clear the flags or read a key's hold time.
// ----------------------------------------------------------------------------
// The registered result appears on rsp_valid/rsp_data the cycle after transfer.
// Throughput: one request per cycle; the single result register refills in
// the cycle it drains, so req_stall rises only while a result is stalled.
// Reset (rst, synchronous): clears all counters and flags, drops rsp_valid,
// and loads repeat_enable 0, short_threshold 100, long_threshold 1000.
// ----------------------------------------------------------------------------
module key_press_classifier (
  input  logic                  clk,
  input  logic                  rst,
  // request channel
  input  logic                  req_valid,
  output logic                  req_stall,
  input  kpc_pkg::req_t         req_data,
  // result channel
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output kpc_pkg::rsp_t         rsp_data,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [kpc_pkg::CFG_WIDTH-1:0] cfg_data
);

  logic                          accept;
  logic [kpc_pkg::LEVEL_BITS-1:0] repeat_enable;
  kpc_pkg::thr_t                 short_threshold;
  kpc_pkg::thr_t                 long_threshold;
  kpc_pkg::lane_ctl_t            ctl [kpc_pkg::NUM_KEYS];
  kpc_pkg::lane_sts_t            sts [kpc_pkg::NUM_KEYS];

  // Hold new requests only while the result register is full and stalled.
  assign req_stall = rsp_valid & rsp_stall;
  assign accept    = req_valid & ~req_stall;

  // Configuration registers; writes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_enable   <= '0;
      short_threshold <= kpc_pkg::SHORT_RESET;
      long_threshold  <= kpc_pkg::LONG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        kpc_pkg::REG_REPEAT: repeat_enable   <= cfg_data[kpc_pkg::LEVEL_BITS-1:0];
        kpc_pkg::REG_SHORT:  short_threshold <= cfg_data[kpc_pkg::THR_WIDTH-1:0];
        kpc_pkg::REG_LONG:   long_threshold  <= cfg_data[kpc_pkg::THR_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // One lane per key. Every lane sees a tick; a flag clear goes only to the
  // lane that key_index selects. Keys without a level bit read as released
  // and never repeat.
  for (genvar k = 0; k < kpc_pkg::NUM_KEYS; k++) begin : g_lane
    always_comb begin
      ctl[k].tick      = accept && (req_data.req_type == kpc_pkg::REQ_TICK);
      ctl[k].pressed   = 1'b0;
      ctl[k].repeat_on = 1'b0;
      if (k < kpc_pkg::LEVEL_BITS) begin
        ctl[k].pressed   = ~req_data.key_levels[k % kpc_pkg::LEVEL_BITS];
        ctl[k].repeat_on = repeat_enable[k % kpc_pkg::LEVEL_BITS];
      end
      ctl[k].clr_press = accept && (req_data.req_type == kpc_pkg::REQ_PRESS)
                         && (int'(req_data.key_index) == k);
      ctl[k].clr_long  = accept && (req_data.req_type == kpc_pkg::REQ_LONG)
                         && (int'(req_data.key_index) == k);
    end

    kpc_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl[k]),
      .short_thr (short_threshold),
      .long_thr  (long_threshold),
      .sts       (sts[k])
    );
  end

  // Merge: activity flag, query selection and the result register.
  kpc_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req       (req_data),
    .lanes     (sts),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp_data  (rsp_data)
  );

endmodule

// ===== src/kpc_checker.sv =====
// ----------------------------------------------------------------------------
// kpc_checker
// Port-level checks for the key press classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "key_press_classifier_macros.svh"

module kpc_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_stall,
  input kpc_pkg::req_t         req_data,
  input logic                  rsp_valid,
  input logic                  rsp_stall,
  input kpc_pkg::rsp_t         rsp_data
);

  logic req_fire;
  logic req_tick;
  logic rsp_held;
  logic rsp_zero;

  assign req_fire = req_valid && !req_stall;
  assign req_tick = (req_data.req_type == kpc_pkg::REQ_TICK);
  assign rsp_held = rsp_valid && rsp_stall;
  assign rsp_zero = (rsp_data.flag == 1'b0) && (rsp_data.hold_time == '0);

  `KPC_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_data), "stalled result changed")
  `KPC_ASSERT_NOW(a_no_idle_stall, !rsp_stall, !req_stall, "request stalled, result side free")
  `KPC_ASSERT_NEXT(a_one_cycle, req_fire, rsp_valid, "accepted request gave no result")
  `KPC_ASSERT_NEXT(a_tick_zero, req_fire && req_tick, rsp_zero, "tick result not zero")

endmodule

bind key_press_classifier kpc_checker u_kpc_checker (.*);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for key_press_classifier. A queue-fed driver offers
// tick and query requests with random gaps, a monitor takes results with
// random stalls, and an in-bench model of the key counters and flags
// predicts every result. Thresholds and the repeat mask change between
// phases, only while the block is drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import kpc_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 200;
  localparam int HOLD_OFF_AT   = 600;
  localparam int HOLD_OFF_LEN  = 80;
  localparam int TAIL_CYCLES   = 4;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_t                 req_data  = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_t                 rsp_data;
  logic                 cfg_we    = 1'b0;
  logic [1:0]           cfg_index = REG_REPEAT;
  logic [CFG_WIDTH-1:0] cfg_data  = '0;

  key_press_classifier dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Requests waiting to be offered, and results owed by the block.
  req_t pending_req[$];
  rsp_t expected_rsp[$];

  // Shadow copy of the block's configuration and per-key state.
  logic [LEVEL_BITS-1:0] rep_mask;
  thr_t                  short_thr;
  thr_t                  long_thr;
  count_t                key_count [NUM_KEYS];
  bit                    key_debounced [NUM_KEYS];
  bit                    key_short [NUM_KEYS];
  bit                    key_long [NUM_KEYS];
  bit                    any_activity;

  // Set per phase: when high, neither side draws random gaps or stalls (the one long hold-off still applies).
  bit no_idle = 1'b0;

  int fail_count    = 0;
  int cycle_count   = 0;
  int results_seen  = 0;
  int gap_left      = 0;
  int wait_left     = 0;
  int hold_off_left = 0;

  bit   nxt_valid;
  req_t nxt_data;
  bit   stall_nxt;
  rsp_t want;

  // Advance the shadow state by one request and return the result it owes.
  function automatic rsp_t predict_rsp(req_t rq);
    rsp_t r;
    bit   pressed;
    int   k;
    r = '0;
    case (req_code_t'(rq.req_type))
      REQ_TICK: begin
        for (k = 0; k < NUM_KEYS; k++) begin
          // keys beyond the level bits read as released
          pressed = (k < LEVEL_BITS) && !rq.key_levels[k];
          if (pressed) begin
            if (key_count[k] != '1)
              key_count[k]++;
            if (key_count[k] > short_thr) begin
              any_activity = 1'b1;
              if (key_count[k] > long_thr) begin
                if (key_debounced[k])
                  key_long[k] = 1'b1;
              end else if (!(k < LEVEL_BITS && rep_mask[k])) begin
                key_debounced[k] = 1'b1;
              end else begin
                // auto-repeat: flag a press and restart the count
                key_short[k] = 1'b1;
                key_count[k] = '0;
              end
            end
          end else begin
            // short press only when debounced and no long press pending
            if (!(k < LEVEL_BITS && rep_mask[k]) && key_debounced[k] && !key_long[k])
              key_short[k] = 1'b1;
            key_count[k]     = '0;
            key_debounced[k] = 1'b0;
            key_long[k]      = 1'b0;
          end
        end
      end
      REQ_ACT: begin
        r.flag       = any_activity;
        any_activity = 1'b0;
      end
      REQ_PRESS: begin
        if (rq.key_index < NUM_KEYS) begin
          r.flag                  = key_short[rq.key_index];
          key_short[rq.key_index] = 1'b0;
        end
      end
      REQ_LONG: begin
        if (rq.key_index < NUM_KEYS) begin
          r.flag                 = key_long[rq.key_index];
          key_long[rq.key_index] = 1'b0;
        end
      end
      REQ_HOLD: begin
        if (rq.key_index < NUM_KEYS)
          r.hold_time = key_count[rq.key_index];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic req_t make_req(logic [2:0] kind, logic [LEVEL_BITS-1:0] lv,
                                    logic [1:0] idx);
    req_t rq;
    rq.req_type   = kind;
    rq.key_levels = lv;
    rq.key_index  = idx;
    return rq;
  endfunction

  // Hold until nothing is queued, offered or owed.
  task automatic wait_drained();
    do
      @(negedge clk);
    while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0);
  endtask

  // Write one register and mirror it in the shadow configuration.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_WIDTH-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_REPEAT: rep_mask  = val[LEVEL_BITS-1:0];
      REG_SHORT:  short_thr = val;
      REG_LONG:   long_thr  = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Run limit: end as a failure if the bench stops making progress.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Request driver: on each transfer, predict the result and draw a gap;
  // once the gap runs out, offer the next queued request. The payload
  // holds still while the block stalls it.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      gap_left = 0;
    end else begin
      nxt_valid = req_valid;
      nxt_data  = req_data;
      if (req_valid && !req_stall) begin
        expected_rsp.push_back(predict_rsp(req_data));
        nxt_valid = 1'b0;
        gap_left  = no_idle ? 0 : int'($urandom_range(0, 9));
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_req.size() != 0) begin
          nxt_data  = pending_req.pop_front();
          nxt_valid = 1'b1;
        end
      end
      // one nonblocking update per signal per edge
      req_valid <= nxt_valid;
      req_data  <= nxt_data;
    end
  end

  // Result monitor: check each transfer against the oldest prediction,
  // then draw a stall for the next one. Once, deep in the run, hold off
  // for a long stretch so the result register fills and the input stalls.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      wait_left     = 0;
      hold_off_left = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          $error("result transfer with no prediction waiting");
          fail_count++;
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_data.flag !== want.flag) begin
            $error("flag: expected %0d, got %0d", want.flag, rsp_data.flag);
            fail_count++;
          end
          if (rsp_data.hold_time !== want.hold_time) begin
            $error("hold_time: expected %0d, got %0d", want.hold_time,
                   rsp_data.hold_time);
            fail_count++;
          end
        end
        results_seen++;
        wait_left = no_idle ? 0 : int'($urandom_range(0, 9));
        if (results_seen == HOLD_OFF_AT)
          hold_off_left = HOLD_OFF_LEN;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        stall_nxt = 1'b1;
      end else if (wait_left > 0) begin
        wait_left--;
        stall_nxt = 1'b1;
      end else begin
        stall_nxt = 1'b0;
      end
      rsp_stall <= stall_nxt;
    end
  end

  // Stimulus: directed requests at the reset configuration and at a small
  // hand-picked one, then random phases that sweep the thresholds and the
  // repeat mask. Each phase begins only after the block has drained.
  initial begin
    int                    p;
    int                    n;
    int                    roll;
    int                    k;
    logic [LEVEL_BITS-1:0] cur_levels;
    logic [CFG_WIDTH-1:0]  s_val;
    logic [CFG_WIDTH-1:0]  l_val;
    logic [CFG_WIDTH-1:0]  m_val;
    req_t                  rq;

    rep_mask     = '0;
    short_thr    = SHORT_RESET;
    long_thr     = LONG_RESET;
    any_activity = 1'b0;
    for (k = 0; k < NUM_KEYS; k++) begin
      key_count[k]     = '0;
      key_debounced[k] = 1'b0;
      key_short[k]     = 1'b0;
      key_long[k]      = 1'b0;
    end
    cur_levels = '1;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: empty flags, out-of-range key, unknown codes,
    // a few all-pressed ticks, then release.
    pending_req.push_back(make_req(REQ_PRESS, 3'b111, 2'd0));
    pending_req.push_back(make_req(REQ_HOLD,  3'b000, 2'd3));
    pending_req.push_back(make_req(3'd5,      3'b000, 2'd1));
    pending_req.push_back(make_req(3'd6,      3'b101, 2'd2));
    pending_req.push_back(make_req(3'd7,      3'b111, 2'd3));
    pending_req.push_back(make_req(REQ_TICK,  3'b000, 2'd3));
    pending_req.push_back(make_req(REQ_TICK,  3'b000, 2'd0));
    pending_req.push_back(make_req(REQ_HOLD,  3'b000, 2'd2));
    pending_req.push_back(make_req(REQ_TICK,  3'b111, 2'd0));
    wait_drained();

    // Key 0 runs long, key 1 makes a short press, key 2 auto-repeats.
    write_reg(REG_REPEAT, 16'h0004);
    write_reg(REG_SHORT,  16'd2);
    write_reg(REG_LONG,   16'd5);
    repeat (3) pending_req.push_back(make_req(REQ_TICK, 3'b000, 2'd0));
    repeat (4) pending_req.push_back(make_req(REQ_TICK, 3'b010, 2'd1));
    pending_req.push_back(make_req(REQ_PRESS, 3'b000, 2'd1));
    pending_req.push_back(make_req(REQ_PRESS, 3'b000, 2'd1));
    pending_req.push_back(make_req(REQ_LONG,  3'b000, 2'd0));
    pending_req.push_back(make_req(REQ_LONG,  3'b000, 2'd0));
    pending_req.push_back(make_req(REQ_HOLD,  3'b000, 2'd0));
    pending_req.push_back(make_req(REQ_HOLD,  3'b000, 2'd2));
    pending_req.push_back(make_req(REQ_PRESS, 3'b000, 2'd2));
    pending_req.push_back(make_req(REQ_ACT,   3'b000, 2'd3));
    pending_req.push_back(make_req(REQ_ACT,   3'b000, 2'd0));
    pending_req.push_back(make_req(REQ_TICK,  3'b111, 2'd2));
    pending_req.push_back(make_req(REQ_PRESS, 3'b000, 2'd0));
    pending_req.push_back(make_req(REQ_LONG,  3'b000, 2'd3));

    for (p = 0; p < PHASES; p++) begin
      wait_drained();
      no_idle = (p % 3 == 2);
      // Sweep the extremes first, then small random thresholds that held
      // keys actually cross.
      case (p)
        0: begin s_val = 16'd0;     l_val = 16'd0;     end
        1: begin s_val = 16'hFFFF;  l_val = 16'hFFFF;  end
        2: begin s_val = 16'd0;     l_val = 16'hFFFF;  end
        default: begin
          s_val = CFG_WIDTH'($urandom_range(0, 8));
          if ($urandom_range(0, 3) == 0)
            l_val = CFG_WIDTH'($urandom_range(0, 8));
          else
            l_val = s_val + CFG_WIDTH'($urandom_range(0, 12));
        end
      endcase
      // upper bits of the mask write are noise the block must drop
      if (p == 1)
        m_val = 16'hFFFF;
      else
        m_val = CFG_WIDTH'($urandom_range(0, 16'hFFFF));
      write_reg(REG_REPEAT, m_val);
      write_reg(REG_SHORT, s_val);
      write_reg(REG_LONG, l_val);

      for (n = 0; n < PHASE_ITEMS; n++) begin
        roll = int'($urandom_range(0, 99));
        rq.key_levels = LEVEL_BITS'($urandom_range(0, 7));
        rq.key_index  = 2'($urandom_range(0, 3));
        if (roll < 60) begin
          // Ticks mostly extend held presses; each key changes level
          // now and then, and a few ticks scramble all levels.
          if ($urandom_range(0, 19) == 0) begin
            cur_levels = LEVEL_BITS'($urandom_range(0, 7));
          end else begin
            for (k = 0; k < LEVEL_BITS; k++)
              if ($urandom_range(0, 5) == 0)
                cur_levels[k] = ~cur_levels[k];
          end
          rq.req_type   = REQ_TICK;
          rq.key_levels = cur_levels;
        end else if (roll < 95) begin
          rq.req_type = 3'($urandom_range(REQ_PRESS, REQ_HOLD));
        end else begin
          rq.req_type = 3'($urandom_range(5, 7));
        end
        pending_req.push_back(rq);
      end
    end

    // Drain, let the pipeline settle, then report.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/kpc_pkg.sv
src/kpc_lane.sv
src/kpc_merge.sv
src/key_press_classifier.sv
src/kpc_checker.sv
test/tb.sv
